// ===== hdl/alps_pkg.sv =====
package alps_pkg;

  localparam logic [1:0] OP_TICK_MS     = 2'd0;
  localparam logic [1:0] OP_TICK_10MS   = 2'd1;
  localparam logic [1:0] OP_ACTIVITY    = 2'd2;

  localparam logic [2:0] REG_LINK_COUNT = 3'd0;
  localparam logic [2:0] REG_DOWN_PRES  = 3'd1;
  localparam logic [2:0] REG_UP_PRES    = 3'd2;
  localparam logic [2:0] REG_SIDE_PRES  = 3'd3;
  localparam logic [2:0] REG_PERIOD     = 3'd4;

  localparam int         PORT_BITS      = 8;
  localparam logic [6:0] MAX_INTERVAL   = 7'd64;
  localparam logic [6:0] STARTUP_RESET  = 7'd100;
  localparam logic [6:0] STARTUP_STEP   = 7'd10;
  localparam logic [15:0] PERIOD_RESET  = 16'd100;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] link_index;
    logic [7:0] down_online;
    logic       up_online;
    logic       side_online;
  } in_item_t;

  typedef struct packed {
    logic [7:0] down_sync;
    logic       up_sync;
    logic       side_sync;
    logic       forced_round;
    logic       started;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  link_count;
    logic [7:0]  downlink_present;
    logic        uplink_present;
    logic        sidelink_present;
    logic [15:0] sync_all_period;
  } cfg_t;

endpackage

// ===== hdl/adaptive_link_poll_scheduler_unit.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_item   (alps_pkg::in_item_t)
// out     | output    | out_valid / out_ready| out_item  (alps_pkg::out_item_t)
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one transaction per cycle unless stalled; result goes input reg -> output reg
// all per-link countdowns and intervals update in parallel in one pass
// rst is synchronous: resets link state, counters and configuration registers
// out_ready low holds the result; one more transaction waits in the input register
// cfg_ready is always high
module adaptive_link_poll_scheduler_unit #(
  parameter int LINKS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  alps_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output alps_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  alps_pkg::cfg_t      cfg;
  alps_pkg::in_item_t  hold_item;
  alps_pkg::out_item_t result;
  logic                hold_valid;
  logic                hold_fire;

  assign cfg_ready = 1'b1;
  assign hold_fire = hold_valid && (!out_valid || out_ready);
  assign in_ready  = !hold_valid || hold_fire;

  alps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  alps_sched #(.LINKS(LINKS)) u_sched (
    .clk    (clk),
    .rst    (rst),
    .fire   (hold_fire),
    .item   (hold_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      hold_valid <= (in_valid && in_ready) || (hold_valid && !hold_fire);
      out_valid  <= hold_fire || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
    if (hold_fire) begin
      out_item <= result;
    end
  end

endmodule

// ===== hdl/alps_cfg.sv =====
module alps_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output alps_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_count       <= '0;
      cfg.downlink_present <= '0;
      cfg.uplink_present   <= 1'b0;
      cfg.sidelink_present <= 1'b0;
      cfg.sync_all_period  <= alps_pkg::PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        alps_pkg::REG_LINK_COUNT: cfg.link_count       <= cfg_data[3:0];
        alps_pkg::REG_DOWN_PRES:  cfg.downlink_present <= cfg_data[7:0];
        alps_pkg::REG_UP_PRES:    cfg.uplink_present   <= cfg_data[0];
        alps_pkg::REG_SIDE_PRES:  cfg.sidelink_present <= cfg_data[0];
        alps_pkg::REG_PERIOD:     cfg.sync_all_period  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/alps_sched.sv =====
module alps_sched #(
  parameter int LINKS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  alps_pkg::in_item_t  item,
  input  alps_pkg::cfg_t      cfg,
  output alps_pkg::out_item_t result
);

  logic [15:0]      round_counter, round_counter_next;
  logic [6:0]       startup_delay, startup_delay_next;
  logic [6:0]       link_countdown [LINKS];
  logic [6:0]       link_countdown_next [LINKS];
  logic [6:0]       link_interval [LINKS];
  logic [6:0]       link_interval_next [LINKS];
  logic [LINKS-1:0] link_grace, link_grace_next;
  logic [LINKS-1:0] dsync;
  logic [7:0]       down_sync_w;
  logic             is_tick, is_slow, is_act, forced;

  assign is_tick = (item.op == alps_pkg::OP_TICK_MS);
  assign is_slow = (item.op == alps_pkg::OP_TICK_10MS);
  assign is_act  = (item.op == alps_pkg::OP_ACTIVITY);
  assign forced  = is_tick && (round_counter == 16'd0);

  always_comb begin
    round_counter_next = round_counter;
    if (is_tick) begin
      round_counter_next = forced ? cfg.sync_all_period : round_counter - 16'd1;
    end
  end

  always_comb begin
    startup_delay_next = startup_delay;
    if (is_slow) begin
      startup_delay_next = (startup_delay > alps_pkg::STARTUP_STEP) ?
                           startup_delay - alps_pkg::STARTUP_STEP : 7'd0;
    end
  end

  for (genvar g = 0; g < LINKS; g++) begin : g_slot
    logic       present, online, in_use, hit, expired;
    logic [6:0] cd_dec;

    if (g < alps_pkg::PORT_BITS) begin : g_bits
      assign present = cfg.downlink_present[g];
      assign online  = item.down_online[g];
    end else begin : g_nobits
      assign present = 1'b0;
      assign online  = 1'b0;
    end

    assign in_use  = {1'b0, cfg.link_count} > 5'(g);
    assign hit     = is_act && (5'(item.link_index) == 5'(g));
    assign cd_dec  = (link_countdown[g] != 7'd0) ? link_countdown[g] - 7'd1 : 7'd0;
    assign expired = (cd_dec == 7'd0);

    assign link_countdown_next[g] =
      hit ? 7'd0 :
      (is_tick && in_use) ? (expired ? link_interval[g] : cd_dec) :
      link_countdown[g];

    assign link_interval_next[g] =
      hit ? 7'd1 :
      (is_slow && in_use && !link_grace[g] && (link_interval[g] < alps_pkg::MAX_INTERVAL)) ?
        {link_interval[g][5:0], 1'b0} :
      link_interval[g];

    assign link_grace_next[g] = hit ? 1'b1 : (is_slow && in_use) ? 1'b0 : link_grace[g];

    assign dsync[g] = is_tick && in_use && (forced || expired) && present && (online || forced);
  end

  for (genvar b = 0; b < alps_pkg::PORT_BITS; b++) begin : g_out
    if (b < LINKS) begin : g_live
      assign down_sync_w[b] = dsync[b];
    end else begin : g_dead
      assign down_sync_w[b] = 1'b0;
    end
  end

  always_comb begin
    result.down_sync    = down_sync_w;
    result.up_sync      = is_tick && cfg.uplink_present && (item.up_online || forced);
    result.side_sync    = is_tick && cfg.sidelink_present && (item.side_online || forced);
    result.forced_round = forced;
    result.started      = (startup_delay_next == 7'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_counter <= '0;
      startup_delay <= alps_pkg::STARTUP_RESET;
      link_grace    <= '1;
      for (int i = 0; i < LINKS; i++) begin
        link_countdown[i] <= '0;
        link_interval[i]  <= 7'd1;
      end
    end else if (fire) begin
      round_counter <= round_counter_next;
      startup_delay <= startup_delay_next;
      link_grace    <= link_grace_next;
      for (int i = 0; i < LINKS; i++) begin
        link_countdown[i] <= link_countdown_next[i];
        link_interval[i]  <= link_interval_next[i];
      end
    end
  end

  // startup delay only counts down
  a_started_holds: assert property (@(posedge clk) disable iff (rst)
    (startup_delay == 7'd0) |=> (startup_delay == 7'd0))
    else $error("startup delay left zero");

  a_forced_reload: assert property (@(posedge clk) disable iff (rst)
    (fire && forced) |=> (round_counter == $past(cfg.sync_all_period)))
    else $error("round counter not reloaded on forced round");

  a_forced_uplink: assert property (@(posedge clk) disable iff (rst)
    (fire && forced) |-> (result.up_sync == cfg.uplink_present))
    else $error("forced round missed the uplink");

endmodule

// ===== tb/tb_adaptive_link_poll_scheduler_unit.sv =====
module tb_adaptive_link_poll_scheduler_unit;

  localparam int NUM_LINKS = 8;
  localparam int NUM_PHASES = 8;
  localparam int RANDOM_PER_PHASE = 255;
  localparam int LONG_HOLD = 60;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    alps_pkg::in_item_t  item;
    logic                typed;
    alps_pkg::out_item_t res;
  } poll_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  alps_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  alps_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  // expectation typed into the table travels alongside the transaction
  logic                row_typed = 1'b0;
  alps_pkg::out_item_t row_res = '0;

  // scheduler model state
  logic [3:0]  m_link_count;
  logic [7:0]  m_down_pres;
  logic        m_up_pres;
  logic        m_side_pres;
  logic [15:0] m_period;
  logic [15:0] m_round;
  logic [6:0]  m_countdown [NUM_LINKS];
  logic [6:0]  m_interval [NUM_LINKS];
  logic        m_grace [NUM_LINKS];
  logic [6:0]  m_startup;

  alps_pkg::out_item_t expected_polls [$];
  int          mismatches = 0;
  int          phase_no = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  bit          held_long = 1'b0;

  poll_row_t directed_rows [24] = '{
    {alps_pkg::OP_TICK_MS,   3'd0, 8'h00, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0},
    {alps_pkg::OP_TICK_MS,   3'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_MS,   3'd7, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_MS,   3'd0, 8'hAA, 1'b1, 1'b0, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_MS,   3'd0, 8'h55, 1'b0, 1'b1, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_10MS, 3'd3, 8'hFF, 1'b1, 1'b1, 1'b1, 8'h00, 4'b0000},
    {alps_pkg::OP_TICK_10MS, 3'd0, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_10MS, 3'd1, 8'h0F, 1'b0, 1'b1, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_10MS, 3'd2, 8'hF0, 1'b1, 1'b0, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_10MS, 3'd4, 8'h33, 1'b0, 1'b0, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_10MS, 3'd5, 8'hCC, 1'b1, 1'b1, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_10MS, 3'd6, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_10MS, 3'd7, 8'hFF, 1'b1, 1'b1, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_10MS, 3'd0, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_10MS, 3'd0, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 4'b0001},
    {alps_pkg::OP_TICK_MS,   3'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 12'h000},
    {alps_pkg::OP_ACTIVITY,  3'd0, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000},
    {alps_pkg::OP_ACTIVITY,  3'd7, 8'hFF, 1'b1, 1'b1, 1'b0, 12'h000},
    {alps_pkg::OP_ACTIVITY,  3'd5, 8'h5A, 1'b0, 1'b1, 1'b0, 12'h000},
    {OP_UNUSED,              3'd2, 8'hFF, 1'b1, 1'b1, 1'b1, 8'h00, 4'b0001},
    {alps_pkg::OP_TICK_MS,   3'd0, 8'h81, 1'b1, 1'b0, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_MS,   3'd0, 8'hFF, 1'b0, 1'b1, 1'b0, 12'h000},
    {alps_pkg::OP_TICK_10MS, 3'd0, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000},
    {alps_pkg::OP_ACTIVITY,  3'd2, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000}
  };

  adaptive_link_poll_scheduler_unit #(
    .LINKS(NUM_LINKS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #3200000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic alps_pkg::out_item_t predict_poll(alps_pkg::in_item_t it);
    alps_pkg::out_item_t r;
    int        n;
    logic      forced;
    logic      want;
    r = '0;
    forced = 1'b0;
    n = (m_link_count > 4'd8) ? NUM_LINKS : int'(m_link_count);
    case (it.op)
      alps_pkg::OP_TICK_MS: begin
        if (m_round == 16'd0) begin
          forced = 1'b1;
          m_round = m_period;
        end else begin
          m_round = m_round - 16'd1;
        end
        for (int i = 0; i < n; i++) begin
          want = forced;
          if (m_countdown[i] != 7'd0) m_countdown[i] = m_countdown[i] - 7'd1;
          if (m_countdown[i] == 7'd0) begin
            m_countdown[i] = m_interval[i];
            want = 1'b1;
          end
          if (want && m_down_pres[i] && (it.down_online[i] || forced)) r.down_sync[i] = 1'b1;
        end
        r.up_sync = m_up_pres && (it.up_online || forced);
        r.side_sync = m_side_pres && (it.side_online || forced);
        r.forced_round = forced;
      end
      alps_pkg::OP_TICK_10MS: begin
        m_startup = (m_startup > alps_pkg::STARTUP_STEP) ?
                    m_startup - alps_pkg::STARTUP_STEP : 7'd0;
        for (int i = 0; i < n; i++) begin
          if (m_grace[i]) m_grace[i] = 1'b0;
          else if (m_interval[i] < alps_pkg::MAX_INTERVAL)
            m_interval[i] = {m_interval[i][5:0], 1'b0};
        end
      end
      alps_pkg::OP_ACTIVITY: begin
        m_countdown[it.link_index] = 7'd0;
        m_interval[it.link_index] = 7'd1;
        m_grace[it.link_index] = 1'b1;
      end
      default: begin
      end
    endcase
    r.started = (m_startup == 7'd0);
    return r;
  endfunction

  function automatic alps_pkg::in_item_t random_poll_item();
    alps_pkg::in_item_t it;
    logic [31:0]        raw;
    int                 pick;
    raw = $urandom;
    it = raw[$bits(alps_pkg::in_item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 60) it.op = alps_pkg::OP_TICK_MS;
    else if (pick < 75) it.op = alps_pkg::OP_TICK_10MS;
    else if (pick < 95) it.op = alps_pkg::OP_ACTIVITY;
    else it.op = OP_UNUSED;
    pick = $urandom_range(0, 7);
    if (pick < 2) it.down_online = 8'hFF;
    else if (pick == 2) it.down_online = 8'h00;
    return it;
  endfunction

  // scoreboard and model update
  always @(posedge clk) begin : scoreboard
    alps_pkg::out_item_t want;
    if (rst) begin
      m_link_count = '0;
      m_down_pres = '0;
      m_up_pres = 1'b0;
      m_side_pres = 1'b0;
      m_period = alps_pkg::PERIOD_RESET;
      m_round = '0;
      m_startup = alps_pkg::STARTUP_RESET;
      for (int i = 0; i < NUM_LINKS; i++) begin
        m_countdown[i] = '0;
        m_interval[i] = 7'd1;
        m_grace[i] = 1'b1;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          alps_pkg::REG_LINK_COUNT: m_link_count = cfg_data[3:0];
          alps_pkg::REG_DOWN_PRES:  m_down_pres = cfg_data[7:0];
          alps_pkg::REG_UP_PRES:    m_up_pres = cfg_data[0];
          alps_pkg::REG_SIDE_PRES:  m_side_pres = cfg_data[0];
          alps_pkg::REG_PERIOD:     m_period = cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_polls.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result %h", $time, out_item);
        end else begin
          want = expected_polls.pop_front();
          if (out_item.down_sync !== want.down_sync || out_item.up_sync !== want.up_sync ||
              out_item.side_sync !== want.side_sync ||
              out_item.forced_round !== want.forced_round ||
              out_item.started !== want.started) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: down_sync %h/%h up %b/%b side %b/%b forced %b/%b started %b/%b",
                       $time, want.down_sync, out_item.down_sync, want.up_sync,
                       out_item.up_sync, want.side_sync, out_item.side_sync,
                       want.forced_round, out_item.forced_round, want.started,
                       out_item.started);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = predict_poll(in_item);
        if (row_typed) want = row_res;
        expected_polls.push_back(want);
      end
    end
  end

  // result side: random stall bursts, one long hold in phase 2
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held_long && phase_no == 2) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held_long = 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_scheduler(alps_pkg::cfg_t c);
    logic [15:0] noise;
    noise = 16'($urandom);
    write_reg(alps_pkg::REG_LINK_COUNT, {noise[15:4], c.link_count});
    write_reg(alps_pkg::REG_DOWN_PRES, {noise[15:8], c.downlink_present});
    write_reg(alps_pkg::REG_UP_PRES, {noise[15:1], c.uplink_present});
    write_reg(alps_pkg::REG_SIDE_PRES, {noise[14:0], c.sidelink_present});
    write_reg(alps_pkg::REG_PERIOD, c.sync_all_period);
    write_reg(REG_UNUSED, noise);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic offer_poll(alps_pkg::in_item_t it, logic typed, alps_pkg::out_item_t res);
    in_valid <= 1'b1;
    in_item <= it;
    row_typed <= typed;
    row_res <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_polls();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_polls.size() != 0) @(posedge clk);
  endtask

  initial begin
    alps_pkg::cfg_t c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      phase_no = p;
      case (p)
        0: begin c = '{4'd8, 8'hFF, 1'b1, 1'b1, 16'd3};      gap_pct = 25; stall_pct = 25; end
        1: begin c = '{4'd15, 8'hA5, 1'b1, 1'b0, 16'd0};     gap_pct = 30; stall_pct = 20; end
        2: begin c = '{4'd0, 8'hFF, 1'b0, 1'b1, 16'd65535};  gap_pct = 10; stall_pct = 15; end
        3: begin c = '{4'd3, 8'h0F, 1'b1, 1'b1, 16'd1};      gap_pct = 0;  stall_pct = 30; end
        4: begin c = '{4'd8, 8'h5A, 1'b0, 1'b0, 16'd6};      gap_pct = 50; stall_pct = 0;  end
        5: begin
          c.link_count = 4'($urandom_range(0, 15));
          c.downlink_present = 8'($urandom);
          c.uplink_present = 1'($urandom);
          c.sidelink_present = 1'($urandom);
          c.sync_all_period = $urandom_range(0, 1) ? 16'($urandom_range(0, 12)) :
                                                     16'($urandom);
          gap_pct = 25;
          stall_pct = 40;
        end
        6: begin c = '{4'd7, 8'h00, 1'b1, 1'b0, 16'd10};     gap_pct = 10; stall_pct = 10; end
        default: begin c = '{4'd5, 8'hFF, 1'b1, 1'b1, 16'd2}; gap_pct = 0;  stall_pct = 0;  end
      endcase
      program_scheduler(c);
      if (p == 0) begin
        foreach (directed_rows[k])
          offer_poll(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].res);
      end else begin
        for (int k = 0; k < RANDOM_PER_PHASE; k++)
          offer_poll(random_poll_item(), 1'b0, '0);
      end
      drain_polls();
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_polls.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
